// ===== rtl/tflpd_pkg.sv =====
package tflpd_pkg;

  // Header layout
  localparam int LONG_HEADER_BYTES = 8;
  localparam int FIFO_DEPTH        = 4;

  localparam logic [7:0] MAGIC_1 = 8'hFF;
  localparam logic [7:0] MAGIC_2 = 8'h53;  // 'S'
  localparam logic [7:0] MAGIC_3 = 8'h46;  // 'F'

  // Header byte positions while a zero-led header is held
  localparam logic [2:0] POS_LEN_HI = 3'd4;
  localparam logic [2:0] POS_LEN_MID = 3'd5;
  localparam logic [2:0] POS_LEN_LO = 3'd6;
  localparam logic [2:0] POS_LAST   = 3'(LONG_HEADER_BYTES - 1);

  // Front-end phase codes
  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_FIRST  = 2'd2;
  localparam logic [1:0] PH_SECOND = 2'd3;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Parameter parts
  localparam logic PART_FIRST  = 1'b0;
  localparam logic PART_SECOND = 1'b1;

  // One queued request: held bytes to release, an optional current byte,
  // an optional end-of-packet report
  typedef struct packed {
    logic [7:0] h3;
    logic [7:0] h4;
    logic [7:0] cur;
    logic [2:0] nheld;
    logic       has_cur;
    logic       cur_part;
    logic       has_rep;
    logic       trunc;
  } cmd_t;

  // Byte k of the releasable held header list (header bytes 1..5)
  function automatic logic [7:0] held_byte(input logic [2:0] k, input logic [7:0] h3,
                                           input logic [7:0] h4);
    logic [7:0] r;
    case (k)
      3'd0:    r = MAGIC_1;
      3'd1:    r = MAGIC_2;
      3'd2:    r = MAGIC_3;
      3'd3:    r = h3;
      default: r = h4;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tflpd_front.sv =====
module tflpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_data,
  input  logic              in_last,
  input  logic              q_full,
  output logic              in_ready,
  output logic              push,
  output tflpd_pkg::cmd_t   cmd
);
  import tflpd_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] frem_r, frem_nxt;
  logic [7:0]  h3_r, h4_r, h5_r;

  logic        accept;
  logic [2:0]  pos;
  logic [7:0]  magic;
  logic        mismatch;
  logic [31:0] len;
  logic [31:0] frem_dec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign pos = (cnt_r == 3'd0) ? 3'd1 : cnt_r;
  always_comb begin
    case (pos)
      3'd1:    magic = MAGIC_1;
      3'd2:    magic = MAGIC_2;
      default: magic = MAGIC_3;
    endcase
  end
  assign mismatch = (pos < POS_LEN_HI) && (in_data != magic);
  assign len      = {h3_r, h4_r, h5_r, in_data};
  assign frem_dec = frem_r - 32'd1;

  // Classify the byte and build the request for the back end
  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    frem_nxt     = frem_r;
    cmd.h3       = h3_r;
    cmd.h4       = h4_r;
    cmd.cur      = in_data;
    cmd.nheld    = 3'd0;
    cmd.has_cur  = 1'b0;
    cmd.cur_part = PART_SECOND;
    cmd.has_rep  = in_last;
    cmd.trunc    = 1'b0;
    case (phase_r)
      PH_START: begin
        if (in_data != 8'd0) begin
          frem_nxt  = {24'd0, in_data};
          phase_nxt = PH_FIRST;
          cmd.trunc = 1'b1;
        end else begin
          cnt_nxt   = 3'd1;
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (mismatch) begin
          cmd.nheld   = pos - 3'd1;
          cmd.has_cur = 1'b1;
          phase_nxt   = PH_SECOND;
        end else if (pos >= POS_LAST) begin
          frem_nxt  = len;
          phase_nxt = (len != 32'd0) ? PH_FIRST : PH_SECOND;
          cmd.trunc = (len != 32'd0);
        end else begin
          cnt_nxt = pos + 3'd1;
          if (in_last) begin
            cmd.nheld   = pos - 3'd1;
            cmd.has_cur = 1'b1;
          end
        end
      end
      PH_FIRST: begin
        cmd.has_cur  = 1'b1;
        cmd.cur_part = PART_FIRST;
        frem_nxt     = frem_dec;
        if (frem_dec == 32'd0) phase_nxt = PH_SECOND;
        cmd.trunc    = (frem_dec != 32'd0);
      end
      default: begin
        cmd.has_cur = 1'b1;
      end
    endcase
    // Packet end returns to packet start
    if (in_last) begin
      phase_nxt = PH_START;
      cnt_nxt   = 3'd0;
      frem_nxt  = 32'd0;
    end
  end

  assign push = accept && (cmd.has_cur || cmd.has_rep);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      cnt_r   <= 3'd0;
      frem_r  <= 32'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      frem_r  <= frem_nxt;
    end
  end

  // Held length bytes
  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_HEADER && !mismatch) begin
      if (pos == POS_LEN_HI)  h3_r <= in_data;
      if (pos == POS_LEN_MID) h4_r <= in_data;
      if (pos == POS_LEN_LO)  h5_r <= in_data;
    end
  end

endmodule

// ===== rtl/tflpd_fifo.sv =====
module tflpd_fifo #(
  parameter int DEPTH = tflpd_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tflpd_pkg::cmd_t   wr_cmd,
  input  logic              pop,
  output tflpd_pkg::cmd_t   rd_cmd,
  output logic              full,
  output logic              empty
);
  import tflpd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == CW'(0));
  assign rd_cmd = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (pop)
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      if (push && !pop)
        count_r <= count_r + CW'(1);
      else if (pop && !push)
        count_r <= count_r - CW'(1);
    end
  end

endmodule

// ===== rtl/tflpd_back.sv =====
module tflpd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tflpd_pkg::cmd_t   cmd,
  input  logic              q_empty,
  input  logic              out_ready,
  output logic              pop,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_trunc,
  output logic              out_kind,
  output logic              out_part,
  output logic              out_last
);
  import tflpd_pkg::*;

  logic [2:0] k_r, k_nxt;
  logic [2:0] total;
  logic       fire;

  assign total     = cmd.nheld + {2'd0, cmd.has_cur} + {2'd0, cmd.has_rep};
  assign out_valid = !q_empty;
  assign out_last  = (k_r == total - 3'd1);
  assign fire      = out_valid && out_ready;
  assign pop       = fire && out_last;
  assign k_nxt     = out_last ? 3'd0 : k_r + 3'd1;

  // Pick the result at position k of the request
  always_comb begin
    out_byte  = 8'd0;
    out_trunc = 1'b0;
    out_kind  = KIND_DATA;
    out_part  = PART_SECOND;
    if (k_r < cmd.nheld) begin
      out_byte = held_byte(k_r, cmd.h3, cmd.h4);
    end else if (cmd.has_cur && k_r == cmd.nheld) begin
      out_byte = cmd.cur;
      out_part = cmd.cur_part;
    end else begin
      out_kind  = KIND_REPORT;
      out_part  = PART_FIRST;
      out_trunc = cmd.trunc;
    end
  end

  // Position within the current request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 3'd0;
    end else if (fire) begin
      k_r <= k_nxt;
    end
  end

endmodule

// ===== rtl/two_field_length_prefix_deframer.sv =====
// Length-prefixed two-part deframer.
// Input stream: one packet byte per request on in_tdata, in_tlast on the
// final byte. Output stream: one result per request; out_tuser[0] is the
// kind (0 data byte, 1 end-of-packet report), out_tuser[1] the part (0 first
// parameter, 1 second), out_tdata[7:0] the byte, out_tdata[8] the truncated
// flag of a report. out_tlast marks the final result of one input byte.
// Short form: byte 0 is the first-parameter length. Long form: 00 FF 'S' 'F'
// and a 32-bit big-endian length in bytes 4..7. Bytes after the leading zero
// that do not complete a long header are released later as second-parameter data.
// Each accepted byte's request is registered in the request queue before its results appear.
// Throughput: one byte per cycle in while the request queue has room; the back
// end issues one result per cycle while out_tready is high, so a header
// release (up to 7 results from one byte) holds the output, absorbed by the
// request queue between front and back. in_tready drops only when that queue is full.
// Reset empties the queue and returns to packet start.
// When the receiver stalls, the current result holds and the queue fills;
// bytes keep being taken until it has no room.
module two_field_length_prefix_deframer #(
  parameter int FIFO_DEPTH = tflpd_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] truncated, [15:9] zero
  output logic [1:0]  out_tuser,  // [0] kind, [1] part
  output logic        out_tlast   // last_of_run
);
  import tflpd_pkg::*;

  cmd_t       wr_cmd, rd_cmd;
  logic       push, pop, q_full, q_empty;
  logic [7:0] out_byte;
  logic       out_trunc, out_kind, out_part;

  tflpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .cmd      (wr_cmd)
  );

  tflpd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  tflpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (rd_cmd),
    .q_empty   (q_empty),
    .out_ready (out_tready),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_byte  (out_byte),
    .out_trunc (out_trunc),
    .out_kind  (out_kind),
    .out_part  (out_part),
    .out_last  (out_tlast)
  );

  assign out_tdata = {7'd0, out_trunc, out_byte};
  assign out_tuser = {out_part, out_kind};

  // A report carries no byte and always closes its run
  a_report_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[7:0] == 8'd0 && out_tlast
                                      && !out_tuser[1]))
    else $error("report result malformed");

  // Data results never flag truncation
  a_data_no_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> !out_tdata[8])
    else $error("data result flagged truncated");

  // The rest of a run is already queued
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("run broken before its final result");

  // No push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("request queue overflow");

endmodule

// ===== tb/sv/two_field_length_prefix_deframer_test.sv =====
`timescale 1ns / 100ps

module two_field_length_prefix_deframer_test;
  import tflpd_pkg::*;

  localparam int RANDOM_BYTES = 386;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;

  // One raw packet byte as presented on the input stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packet_byte_t;

  // One deframed result
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       part;
    logic       trunc;
    logic       last;
  } deframe_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] out_byte, [8] truncated, [15:9] zero
  logic [1:0]  out_tuser;          // [0] kind, [1] part
  logic        out_tlast;          // last_of_run

  two_field_length_prefix_deframer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  // Magic header, indexed by byte position
  logic [7:0] magic_seq [0:3] = '{8'h00, MAGIC_1, MAGIC_2, MAGIC_3};

  packet_byte_t    byte_q[$];      // bytes waiting to be sent
  logic [7:0]      pkt_q[$];       // packet under construction
  deframe_result_t step_q[$];      // results of the byte being predicted
  deframe_result_t expect_q[$];    // results still due from the DUT

  // Predictor state
  logic [1:0]  rx_phase = PH_START;
  logic [7:0]  hdr_bytes [0:LONG_HEADER_BYTES-2];
  logic [2:0]  hdr_pos = 3'd0;
  logic [31:0] first_left = 32'd0;

  int n_errors = 0;
  int n_cycles = 0;
  int n_presented = 0;
  int n_accepted = 0;
  int n_total = 0;
  int n_packets = 0;
  int n_results = 0;
  int n_trunc_reports = 0;
  int pause_a = -1;
  int pause_b = -1;
  int burst_left = 1;
  int gap_left = 0;
  int rx_mode = 0;
  int rx_cycle = 0;

  task automatic report_mismatch(input string msg);
    if (n_errors < 40) $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic put_result(input logic kind, input logic [7:0] data, input logic part,
                            input logic trunc);
    deframe_result_t r;
    r.kind  = kind;
    r.data  = data;
    r.part  = part;
    r.trunc = trunc;
    r.last  = 1'b0;
    step_q.insert(step_q.size(), r);
  endtask

  // Held header bytes 1..pos-1, then the current byte, all as second part
  task automatic release_held(input logic [2:0] pos, input logic [7:0] cur);
    for (int i = 1; i < pos; i++) put_result(KIND_DATA, hdr_bytes[i-1], PART_SECOND, 1'b0);
    put_result(KIND_DATA, cur, PART_SECOND, 1'b0);
  endtask

  // Expected results for one accepted packet byte
  task automatic deframe_byte(input logic [7:0] b, input logic lst);
    logic [2:0]      pos;
    deframe_result_t tail;
    case (rx_phase)
      PH_START: begin
        if (b != 8'h00) begin
          first_left = {24'd0, b};
          rx_phase = PH_FIRST;
        end else begin
          hdr_pos = 3'd1;
          rx_phase = PH_HEADER;
        end
      end
      PH_HEADER: begin
        pos = (hdr_pos == 3'd0) ? 3'd1 : hdr_pos;
        if (pos < 3'd4 && b != magic_seq[pos[1:0]]) begin
          release_held(pos, b);
          rx_phase = PH_SECOND;
        end else if (pos >= POS_LAST) begin
          first_left = {hdr_bytes[POS_LEN_HI-1], hdr_bytes[POS_LEN_MID-1],
                        hdr_bytes[POS_LEN_LO-1], b};
          rx_phase = (first_left != 32'd0) ? PH_FIRST : PH_SECOND;
        end else begin
          hdr_bytes[pos-1] = b;
          hdr_pos = pos + 3'd1;
          if (lst) begin
            release_held(pos, b);
            rx_phase = PH_SECOND;
          end
        end
      end
      PH_FIRST: begin
        put_result(KIND_DATA, b, PART_FIRST, 1'b0);
        first_left = first_left - 32'd1;
        if (first_left == 32'd0) rx_phase = PH_SECOND;
      end
      default: put_result(KIND_DATA, b, PART_SECOND, 1'b0);
    endcase

    // end of packet: report, then back to packet start
    if (lst) begin
      put_result(KIND_REPORT, 8'h00, PART_FIRST,
                 (rx_phase == PH_FIRST) && (first_left != 32'd0));
      rx_phase = PH_START;
      hdr_pos = 3'd0;
      first_left = 32'd0;
    end

    if (step_q.size() != 0) begin
      tail = step_q.pop_back();
      tail.last = 1'b1;
      step_q.insert(step_q.size(), tail);
    end
    while (step_q.size() != 0) expect_q.insert(expect_q.size(), step_q.pop_front());
  endtask

  // Packet building
  task automatic add_byte(input logic [7:0] b);
    pkt_q.insert(pkt_q.size(), b);
  endtask

  task automatic add_payload(input int n);
    repeat (n) add_byte(8'($urandom));
  endtask

  task automatic add_long_header(input logic [31:0] len);
    add_byte(8'h00);
    add_byte(MAGIC_1);
    add_byte(MAGIC_2);
    add_byte(MAGIC_3);
    add_byte(len[31:24]);
    add_byte(len[23:16]);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
  endtask

  task automatic end_packet();
    packet_byte_t it;
    for (int i = 0; i < pkt_q.size(); i++) begin
      it.data = pkt_q[i];
      it.last = (i == pkt_q.size() - 1);
      byte_q.insert(byte_q.size(), it);
    end
    pkt_q.delete();
    n_packets++;
  endtask

  // Sender: bursts of requests with random gaps, plus drain pauses
  always @(posedge clk) begin
    packet_byte_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        deframe_byte(in_tdata, in_tlast);
        n_accepted++;
      end
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (byte_q.size() == 0 ||
                   ((n_presented == pause_a || n_presented == pause_b) &&
                    expect_q.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        it = byte_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= it.data;
        in_tlast  <= it.last;
        n_presented++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: stall pattern drawn at random from four modes
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (rx_cycle % 5) < 2;
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    deframe_result_t exp_r;
    n_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      if (expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                                  out_tdata, out_tuser, out_tlast));
      end else begin
        exp_r = expect_q.pop_front();
        n_results++;
        if (exp_r.kind == KIND_REPORT && exp_r.trunc) n_trunc_reports++;
        if (out_tuser[0] !== exp_r.kind || out_tuser[1] !== exp_r.part ||
            out_tdata[7:0] !== exp_r.data || out_tdata[8] !== exp_r.trunc ||
            out_tdata[15:9] !== 7'd0 || out_tlast !== exp_r.last) begin
          report_mismatch($sformatf(
            "got kind=%b part=%b byte=%h trunc=%b hi=%h last=%b, want %b %b %h %b 00 %b",
            out_tuser[0], out_tuser[1], out_tdata[7:0], out_tdata[8], out_tdata[15:9],
            out_tlast, exp_r.kind, exp_r.part, exp_r.data, exp_r.trunc, exp_r.last));
        end
      end
    end
  end

  initial begin
    int         sel;
    int         lenv;
    int         n;
    int         k;
    logic [7:0] b;
    logic [31:0] len32;
    logic       timed_out;

    // Directed packets
    add_byte(8'h00); end_packet();                    // lone zero header byte
    add_byte(8'hFF); end_packet();                    // short length, nothing follows
    add_byte(8'h01); add_byte(8'hAA); add_byte(8'h55); end_packet();
    add_byte(8'h00); add_byte(8'h12); add_byte(8'h34); end_packet();  // magic mismatch
    add_byte(8'h00); add_byte(MAGIC_1); add_byte(MAGIC_2); add_byte(MAGIC_3);
    add_byte(8'h80); add_byte(8'h7F); add_byte(8'hC3); end_packet();  // ends in header
    add_long_header(32'd0); add_byte(8'h77); end_packet();            // long length zero
    pause_a = byte_q.size();

    // Random packets, mostly well formed
    while (byte_q.size() < pause_a + RANDOM_BYTES) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        lenv = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
        add_byte(8'(lenv));
        if (lenv > 6) n = $urandom_range(0, 6);
        else if ($urandom_range(0, 4) == 0) n = $urandom_range(0, lenv - 1);
        else n = lenv + $urandom_range(0, 4);
        add_payload(n);
      end else if (sel < 70) begin
        k = $urandom_range(0, 19);
        if (k < 2) len32 = 32'd0;
        else if (k < 5) len32 = $urandom;
        else len32 = $urandom_range(1, 6);
        add_long_header(len32);
        if (len32 <= 32'd6 && $urandom_range(0, 3) != 0) n = len32 + $urandom_range(0, 3);
        else n = $urandom_range(0, 5);
        add_payload(n);
      end else if (sel < 85) begin
        // broken magic at position 1..3
        k = $urandom_range(0, 2);
        add_byte(8'h00);
        for (int j = 1; j <= k; j++) add_byte(magic_seq[j]);
        b = 8'($urandom);
        if (b == magic_seq[k+1]) b = b ^ 8'h01;
        add_byte(b);
        add_payload($urandom_range(0, 4));
      end else begin
        // packet ends inside a zero-led header
        k = $urandom_range(0, 6);
        add_byte(8'h00);
        for (int j = 1; j <= k; j++) add_byte((j < 4) ? magic_seq[j] : 8'($urandom));
      end
      end_packet();
    end
    n_total = byte_q.size();
    pause_b = pause_a + n_total / 2;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (!(n_accepted == n_total && expect_q.size() == 0) && n_cycles < CYCLE_LIMIT)
      @(posedge clk);
    timed_out = (n_cycles >= CYCLE_LIMIT);

    if (!timed_out) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (expect_q.size() != 0)
        report_mismatch($sformatf("%0d expected results never arrived", expect_q.size()));
    end else begin
      report_mismatch($sformatf("run stopped after %0d cycles, %0d of %0d bytes accepted",
                                n_cycles, n_accepted, n_total));
    end

    $display("Sent %0d packets (%0d bytes): short, long, broken and cut-off headers.",
             n_packets, n_accepted);
    $display("Checked %0d results, %0d truncation reports, in %0d cycles.",
             n_results, n_trunc_reports, n_cycles);
    if (n_errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
